>>> design/pcsd_pkg.sv
// shared types and constants for the point to cuboid set distance block
`default_nettype none

package pcsd_pkg;

    // table size and field widths
    localparam int MAX_CUBOIDS = 16;
    localparam int COORD_W     = 32;
    localparam int SIDE_W      = 31;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam int OPC_W       = 1;

    // doubled face distances: 2*(p - c) - side fits in 35 signed bits
    localparam int DW = COORD_W + 3;

    // min tree over the lanes, one register level per tree level
    localparam int TREE_LEVELS = (MAX_CUBOIDS > 1) ? $clog2(MAX_CUBOIDS) : 1;
    localparam int TREE_WIDTH  = 1 << TREE_LEVELS;

    // pipeline stage map
    localparam int LANE_STAGES = 3;
    localparam int TREE_FIRST  = LANE_STAGES;
    localparam int PIPE_STAGES = LANE_STAGES + TREE_LEVELS + 1;
    localparam int OUT_STAGE   = PIPE_STAGES - 1;

    // lane count compare width
    localparam int CNT_W = $clog2(MAX_CUBOIDS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_CUBOIDS_IN_USE = 2'd0;

    // opcodes
    localparam logic [OPC_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPC_W-1:0] OP_QUERY = 1'b1;

    localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [SIDE_W-1:0]         sx;
        logic [SIDE_W-1:0]         sy;
        logic [SIDE_W-1:0]         sz;
    } t_cuboid;

    typedef struct packed {
        logic signed [DW-1:0] dist2;
        t_axis                axis;
        logic                 pos;
    } t_face;

    typedef struct packed {
        logic  vld;
        t_face face;
    } t_cand;

endpackage

`default_nettype wire

>>> design/pcsd_table.sv
// cuboid table: one write port, every slot visible to its own lane
`default_nettype none

module pcsd_table (
    input  logic                     i_clk,
    input  logic                     i_wr,
    input  logic [pcsd_pkg::SLOT_W-1:0] i_slot,
    input  pcsd_pkg::t_cuboid        i_entry,
    output pcsd_pkg::t_cuboid        o_tab [pcsd_pkg::MAX_CUBOIDS]
);
    import pcsd_pkg::*;

    t_cuboid r_tab [MAX_CUBOIDS];

    // slots beyond the table never match, so such loads are dropped
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_CUBOIDS; k++) begin
            if (i_wr && (int'(i_slot) == k)) begin
                r_tab[k] <= i_entry;
            end
        end
    end

    assign o_tab = r_tab;

endmodule

`default_nettype wire

>>> design/pcsd_lane.sv
// one cuboid lane: face distances, per-axis pick, best face over the axes
`default_nettype none

module pcsd_lane (
    input  logic                               i_clk,
    input  logic [pcsd_pkg::LANE_STAGES-1:0]   i_en,
    input  pcsd_pkg::t_point                   i_point,
    input  pcsd_pkg::t_cuboid                  i_cuboid,
    output pcsd_pkg::t_face                    o_face
);
    import pcsd_pkg::*;

    logic signed [COORD_W-1:0] w_p [3];
    logic signed [COORD_W-1:0] w_c [3];
    logic [SIDE_W-1:0]         w_h [3];

    logic signed [DW-1:0] n_lo [3];
    logic signed [DW-1:0] n_hi [3];
    logic signed [DW-1:0] r_lo [3];
    logic signed [DW-1:0] r_hi [3];

    t_face n_ax [3];
    t_face r_ax [3];
    t_face n_face;
    t_face r_face;

    assign w_p[0] = i_point.x;
    assign w_p[1] = i_point.y;
    assign w_p[2] = i_point.z;
    assign w_c[0] = i_cuboid.cx;
    assign w_c[1] = i_cuboid.cy;
    assign w_c[2] = i_cuboid.cz;
    assign w_h[0] = i_cuboid.sx;
    assign w_h[1] = i_cuboid.sy;
    assign w_h[2] = i_cuboid.sz;

    // doubled distances to the low and high face planes
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_lo[a] = (DW'(w_c[a]) <<< 1) - (DW'(w_p[a]) <<< 1) - DW'(w_h[a]);
            n_hi[a] = (DW'(w_p[a]) <<< 1) - (DW'(w_c[a]) <<< 1) - DW'(w_h[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // high face wins only when strictly greater
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_ax[a].axis = t_axis'(2'(a));
            if (r_hi[a] > r_lo[a]) begin
                n_ax[a].dist2 = r_hi[a];
                n_ax[a].pos   = 1'b1;
            end else begin
                n_ax[a].dist2 = r_lo[a];
                n_ax[a].pos   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ax <= n_ax;
        end
    end

    // earliest axis with the largest distance
    always_comb begin
        n_face = r_ax[0];
        if (r_ax[1].dist2 > n_face.dist2) begin
            n_face = r_ax[1];
        end
        if (r_ax[2].dist2 > n_face.dist2) begin
            n_face = r_ax[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_face <= n_face;
        end
    end

    assign o_face = r_face;

endmodule

`default_nettype wire

>>> design/pcsd_min_tree.sv
// registered min tree over the lanes, earlier lane wins a tie
`default_nettype none

module pcsd_min_tree (
    input  logic                               i_clk,
    input  logic [pcsd_pkg::TREE_LEVELS-1:0]   i_en,
    input  pcsd_pkg::t_cand                    i_leaf [pcsd_pkg::TREE_WIDTH],
    output pcsd_pkg::t_cand                    o_root
);
    import pcsd_pkg::*;

    // heap order: node i has children 2i and 2i+1, leaves from TREE_WIDTH up
    t_cand w_node [1:2*TREE_WIDTH-1];

    for (genvar k = 0; k < TREE_WIDTH; k++) begin : g_leaf
        assign w_node[TREE_WIDTH + k] = i_leaf[k];
    end

    for (genvar i = 1; i < TREE_WIDTH; i++) begin : g_node
        localparam int LV = $clog2(i + 1) - 1;
        localparam int ST = TREE_LEVELS - 1 - LV;

        t_cand w_pick;
        t_cand r_node;

        // left child covers the earlier lanes
        always_comb begin
            w_pick = w_node[2*i];
            if (w_node[2*i+1].vld &&
                (!w_node[2*i].vld ||
                 (w_node[2*i+1].face.dist2 < w_node[2*i].face.dist2))) begin
                w_pick = w_node[2*i+1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[ST]) begin
                r_node <= w_pick;
            end
        end

        assign w_node[i] = r_node;
    end

    assign o_root = w_node[1];

endmodule

`default_nettype wire

>>> design/point_to_cuboid_set_distance.sv
// top level: signed distance from a point to a table of axis-aligned cuboids
//
// input channel: i_valid / o_stall. a transaction with i_opcode load writes
// one table slot (centre and full side lengths, Q16.16) and gives no result;
// a query transaction carries a point and gives exactly one result.
// output channel: o_valid / i_stall with distance, normal axis and sign, and
// found flag (cleared, distance at its largest value, when no cuboid is used).
// register cuboids_in_use at address 0 sets how many slots from slot zero take
// part; the user must write it only while no query is in flight, which the
// block itself does not enforce. a query's result passes three lane stages,
// one register per min-tree level and one output register.
// throughput: one transaction per cycle while o_stall is low; every cuboid has its own lane.
// a stalled receiver holds the output register; bubbles ahead of it still
// close up, and o_stall rises only when every stage holds a query.
// reset clears valid bits and the register; table slots must be loaded
// before a query uses them.
`default_nettype none

module point_to_cuboid_set_distance (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [pcsd_pkg::OPC_W-1:0]            i_opcode,
    input  logic [pcsd_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [pcsd_pkg::COORD_W-1:0]   i_coord_x,
    input  logic signed [pcsd_pkg::COORD_W-1:0]   i_coord_y,
    input  logic signed [pcsd_pkg::COORD_W-1:0]   i_coord_z,
    input  logic [pcsd_pkg::SIDE_W-1:0]           i_length_x,
    input  logic [pcsd_pkg::SIDE_W-1:0]           i_length_y,
    input  logic [pcsd_pkg::SIDE_W-1:0]           i_length_z,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pcsd_pkg::COORD_W-1:0]   o_distance,
    output logic [1:0]                            o_normal_axis,
    output logic                                  o_normal_positive,
    output logic                                  o_found_cuboid,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pcsd_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [pcsd_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [pcsd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import pcsd_pkg::*;

    logic [CFG_W-1:0]       r_cuboids_in_use;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] w_en;
    logic                   w_accept;
    logic                   w_load;
    logic                   w_query;
    logic [CMP_W-1:0]       w_cfg_ext;
    logic [CMP_W-1:0]       w_n_sat;

    t_point  w_point;
    t_cuboid w_entry;
    t_cuboid w_tab  [MAX_CUBOIDS];
    t_face   w_face [MAX_CUBOIDS];
    t_cand   w_leaf [TREE_WIDTH];
    t_cand   w_root;

    logic signed [DW-1:0]      w_half;
    logic signed [DW-1:0]      w_sat_hi;
    logic signed [DW-1:0]      w_sat_lo;
    logic signed [COORD_W-1:0] n_distance;
    t_axis                     n_axis;
    logic                      n_pos;
    logic                      n_found;
    logic signed [COORD_W-1:0] r_distance;
    t_axis                     r_axis;
    logic                      r_pos;
    logic                      r_found;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cuboids_in_use <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_CUBOIDS_IN_USE)) begin
            r_cuboids_in_use <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CUBOIDS_IN_USE) begin
            prdata = APB_DATA_W'(r_cuboids_in_use);
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[OUT_STAGE] = !r_vld[OUT_STAGE] || !i_stall;
        for (int s = OUT_STAGE - 1; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_stall  = !w_en[0];
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && (i_opcode == OP_LOAD);
    assign w_query  = w_accept && (i_opcode == OP_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_query;
            end
            for (int s = 1; s < PIPE_STAGES; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // table
    assign w_entry.cx = i_coord_x;
    assign w_entry.cy = i_coord_y;
    assign w_entry.cz = i_coord_z;
    assign w_entry.sx = i_length_x;
    assign w_entry.sy = i_length_y;
    assign w_entry.sz = i_length_z;

    pcsd_table u_table (
        .i_clk   (i_clk),
        .i_wr    (w_load),
        .i_slot  (i_slot),
        .i_entry (w_entry),
        .o_tab   (w_tab)
    );

    // lanes read the table as it stands when the query transaction completes
    assign w_point.x = i_coord_x;
    assign w_point.y = i_coord_y;
    assign w_point.z = i_coord_z;

    for (genvar k = 0; k < MAX_CUBOIDS; k++) begin : g_lane
        pcsd_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en[LANE_STAGES-1:0]),
            .i_point  (w_point),
            .i_cuboid (w_tab[k]),
            .o_face   (w_face[k])
        );
    end

    // lanes in use, register saturated to the table size
    assign w_cfg_ext = CMP_W'(r_cuboids_in_use);
    assign w_n_sat   = (w_cfg_ext > CMP_W'(MAX_CUBOIDS)) ? CMP_W'(MAX_CUBOIDS) : w_cfg_ext;

    for (genvar k = 0; k < TREE_WIDTH; k++) begin : g_leaf
        if (k < MAX_CUBOIDS) begin : g_used
            assign w_leaf[k].vld  = CMP_W'(k) < w_n_sat;
            assign w_leaf[k].face = w_face[k];
        end else begin : g_pad
            assign w_leaf[k] = '0;
        end
    end

    pcsd_min_tree u_min_tree (
        .i_clk  (i_clk),
        .i_en   (w_en[TREE_FIRST +: TREE_LEVELS]),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // halve with floor, then saturate
    assign w_half   = $signed(w_root.face.dist2) >>> 1;
    assign w_sat_hi = DW'(DIST_MAX);
    assign w_sat_lo = DW'(DIST_MIN);

    always_comb begin
        n_found    = w_root.vld;
        n_axis     = w_root.face.axis;
        n_pos      = w_root.face.pos;
        n_distance = w_half[COORD_W-1:0];
        if (!w_root.vld) begin
            n_distance = DIST_MAX;
            n_axis     = AXIS_X;
            n_pos      = 1'b0;
        end else if (w_half > w_sat_hi) begin
            n_distance = DIST_MAX;
        end else if (w_half < w_sat_lo) begin
            n_distance = DIST_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[OUT_STAGE]) begin
            r_distance <= n_distance;
            r_axis     <= n_axis;
            r_pos      <= n_pos;
            r_found    <= n_found;
        end
    end

    assign o_valid           = r_vld[OUT_STAGE];
    assign o_distance        = r_distance;
    assign o_normal_axis     = r_axis;
    assign o_normal_positive = r_pos;
    assign o_found_cuboid    = r_found;

    // input side only backs up when every stage holds a query
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free stage");

    // a load leaves no query in the first stage
    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_opcode == OP_LOAD)) |=> !r_vld[0])
        else $error("load transaction entered the pipeline");

    // empty cuboid set gives the fixed answer
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found_cuboid) |->
            ((o_distance == DIST_MAX) && (o_normal_axis == AXIS_X) && !o_normal_positive))
        else $error("result without a cuboid is not the fixed answer");

    // output valid rises only when the stage before the output held a query
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid)) |-> $past(r_vld[OUT_STAGE-1]))
        else $error("output valid without a query behind it");

endmodule

`default_nettype wire
